// ===== hw/rtl/ultrasonic_echo_ranging_top_assert.svh =====
// assertion macros for the ultrasonic echo ranging block
// no dependencies, included inside module bodies
`ifndef ULTRASONIC_ECHO_RANGING_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGING_TOP_ASSERT_SVH

// combinational check sampled at every rising edge
`define UER_ASSERT_HOLDS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define UER_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UER_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/uer_pkg.sv =====
// types and constants for the ultrasonic echo ranging block
// no dependencies
package uer_pkg;

   localparam int CYCLES_PER_US = 100;
   localparam int US_PER_MS     = 1000;

   localparam int US_PRE_W = (CYCLES_PER_US > 1) ? $clog2(CYCLES_PER_US) : 1;
   localparam int MS_PRE_W = $clog2(US_PER_MS);

   localparam logic [US_PRE_W:0] US_WRAP = (US_PRE_W + 1)'(CYCLES_PER_US);
   localparam logic [MS_PRE_W:0] MS_WRAP = (MS_PRE_W + 1)'(US_PER_MS);

   localparam int PHASE_W = 4;
   localparam logic [PHASE_W-1:0] TRIG_LOW_US = 4'd2;
   localparam logic [PHASE_W-1:0] TRIG_END_US = 4'd12;

   localparam int ECHO_W = 18;
   localparam logic [ECHO_W-1:0] ECHO_US_MAX = {ECHO_W{1'b1}};

   // mm = us * 10 / 58 = (us * 5) / 29, by reciprocal multiply
   localparam int SCALED_W  = ECHO_W + 3;
   localparam int DIV_SHIFT = 26;
   localparam int DIV_MUL_W = 22;
   localparam logic [DIV_MUL_W-1:0] DIV_MUL = 22'd2314099;
   localparam int PROD_W    = SCALED_W + DIV_MUL_W + 1;

   localparam logic [7:0]  MS_SAT        = 8'd255;
   localparam logic [7:0]  TIMEOUT_RESET = 8'd30;
   localparam logic [7:0]  GAP_RESET     = 8'd60;
   localparam logic [15:0] MAX_MM_RESET  = 16'd4000;

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CSR_TIMEOUT = 2'd0,
      CSR_GAP     = 2'd1,
      CSR_MAX_MM  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'b01,
      MODE_BUSY = 2'b10
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_IDLE    = 2'd0,
      STATUS_BUSY    = 2'd1,
      STATUS_DONE    = 2'd2,
      STATUS_TIMEOUT = 2'd3
   } status_type;

   typedef struct packed {
      logic        distance_valid;
      logic [15:0] range_mm;
      logic        start_accepted;
      status_type  status;
      logic        trig;
   } rsp_type;

endpackage

// ===== hw/rtl/ultrasonic_echo_ranging_top.sv =====
// throughput: one transaction per cycle while req_tready is high (skid entry empty)
// a result is registered onto rsp; time base and echo counter advance per transaction
// the two-entry output buffer keeps req_tready high while one result waits
// reset: synchronous, state to idle, gap counter saturated, registers to defaults
// depends on uer_pkg and ultrasonic_echo_ranging_top_assert.svh
module ultrasonic_echo_ranging_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // start_req, echo_level, zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // trig, status, start_accepted,
                                                        // range_mm, zero pad
   output logic                            rsp_tuser,   // distance_valid
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [uer_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import uer_pkg::*;
   `include "ultrasonic_echo_ranging_top_assert.svh"

   logic [7:0]  timeout_ff;
   logic [7:0]  gap_ff;
   logic [15:0] max_mm_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   mode_type              mode_ff, mode_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic                  prev_echo_ff;
   logic                  rise_seen_ff, rise_seen_in;
   logic [US_PRE_W-1:0]   us_pre_ff, us_pre_in;
   logic [MS_PRE_W-1:0]   ms_pre_ff, ms_pre_in;
   logic [ECHO_W-1:0]     echo_us_ff, echo_us_in;
   logic [7:0]            ms_start_ff, ms_start_in;
   logic [7:0]            ms_done_ff, ms_done_in;
   logic [15:0]           last_mm_ff, last_mm_in;
   logic                  last_valid_ff, last_valid_in;

   logic                  req_acc, rsp_pop;
   logic                  start_req, echo_level;
   logic                  rising, falling;
   logic [US_PRE_W:0]     us_sum;
   logic [MS_PRE_W:0]     ms_sum;
   logic                  us_tick, ms_tick;
   logic [US_PRE_W-1:0]   tb_us;
   logic [MS_PRE_W-1:0]   tb_ms;
   logic [ECHO_W-1:0]     echo_tick;
   logic [SCALED_W-1:0]   scaled;
   logic [PROD_W-1:0]     prod;
   logic [15:0]           mm;
   logic                  start_ok;
   status_type            status;
   logic                  trig;
   rsp_type               rsp_new;

   rsp_type               out_ff, skid_ff;
   logic                  out_valid_ff, skid_valid_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         gap_ff     <= GAP_RESET;
         max_mm_ff  <= MAX_MM_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_TIMEOUT: timeout_ff <= csr_pwdata[7:0];
            CSR_GAP:     gap_ff     <= csr_pwdata[7:0];
            CSR_MAX_MM:  max_mm_ff  <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_TIMEOUT: csr_prdata = {24'd0, timeout_ff};
         CSR_GAP:     csr_prdata = {24'd0, gap_ff};
         CSR_MAX_MM:  csr_prdata = {16'd0, max_mm_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   // handshake
   assign req_tready = ~skid_valid_ff;
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_pop    = out_valid_ff & rsp_tready;
   assign start_req  = req_tdata[0];
   assign echo_level = req_tdata[1];

   // time base and echo conversion
   always_comb begin
      rising  = echo_level & ~prev_echo_ff;
      falling = ~echo_level & prev_echo_ff;
      us_sum  = {1'b0, us_pre_ff} + (US_PRE_W + 1)'(1);
      ms_sum  = {1'b0, ms_pre_ff} + (MS_PRE_W + 1)'(1);
      us_tick = (us_sum >= US_WRAP);
      ms_tick = us_tick & (ms_sum >= MS_WRAP);
      tb_us   = us_tick ? '0 : us_sum[US_PRE_W-1:0];
      if (!us_tick) begin
         tb_ms = ms_pre_ff;
      end else if (ms_tick) begin
         tb_ms = '0;
      end else begin
         tb_ms = ms_sum[MS_PRE_W-1:0];
      end
      if (us_tick && rise_seen_ff && (echo_us_ff != ECHO_US_MAX)) begin
         echo_tick = echo_us_ff + ECHO_W'(1);
      end else begin
         echo_tick = echo_us_ff;
      end
      scaled = {1'b0, echo_tick, 2'b00} + SCALED_W'(echo_tick);
      prod   = PROD_W'(scaled) * PROD_W'(DIV_MUL);
      mm     = prod[DIV_SHIFT+15:DIV_SHIFT];
   end

   // measurement control
   always_comb begin
      mode_in       = mode_ff;
      phase_in      = phase_ff;
      rise_seen_in  = rise_seen_ff;
      us_pre_in     = tb_us;
      ms_pre_in     = tb_ms;
      echo_us_in    = echo_us_ff;
      ms_start_in   = ms_start_ff;
      ms_done_in    = ms_done_ff;
      last_mm_in    = last_mm_ff;
      last_valid_in = last_valid_ff;
      status        = STATUS_IDLE;
      start_ok      = 1'b0;
      trig          = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (start_req && (ms_done_ff >= gap_ff)) begin
               start_ok     = 1'b1;
               status       = STATUS_BUSY;
               mode_in      = MODE_BUSY;
               phase_in     = '0;
               rise_seen_in = 1'b0;
               echo_us_in   = '0;
               ms_start_in  = '0;
               us_pre_in    = '0;
               ms_pre_in    = '0;
            end else if (ms_tick && (ms_done_ff != MS_SAT)) begin
               ms_done_in = ms_done_ff + 8'd1;
            end
         end
         MODE_BUSY: begin
            if (us_tick && (phase_ff < TRIG_END_US)) begin
               phase_in = phase_ff + PHASE_W'(1);
            end
            echo_us_in = echo_tick;
            if (ms_tick && (ms_start_ff != MS_SAT)) begin
               ms_start_in = ms_start_ff + 8'd1;
            end
            status = STATUS_BUSY;
            if (rising) begin
               rise_seen_in = 1'b1;
               echo_us_in   = '0;
            end else if (falling && rise_seen_ff) begin
               if ((mm == 16'd0) || (mm > max_mm_ff)) begin
                  last_valid_in = 1'b0;
                  status        = STATUS_TIMEOUT;
               end else begin
                  last_mm_in    = mm;
                  last_valid_in = 1'b1;
                  status        = STATUS_DONE;
               end
            end
            if ((status == STATUS_BUSY) && (ms_start_in >= timeout_ff)) begin
               last_valid_in = 1'b0;
               status        = STATUS_TIMEOUT;
            end
            if (status != STATUS_BUSY) begin
               mode_in      = MODE_IDLE;
               rise_seen_in = 1'b0;
               ms_done_in   = '0;
               us_pre_in    = '0;
               ms_pre_in    = '0;
            end
            trig = (status == STATUS_BUSY) && (phase_in >= TRIG_LOW_US) &&
                   (phase_in < TRIG_END_US);
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
      rsp_new.trig           = trig;
      rsp_new.status         = status;
      rsp_new.start_accepted = start_ok;
      rsp_new.range_mm       = last_mm_in;
      rsp_new.distance_valid = last_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         phase_ff      <= '0;
         prev_echo_ff  <= 1'b0;
         rise_seen_ff  <= 1'b0;
         us_pre_ff     <= '0;
         ms_pre_ff     <= '0;
         echo_us_ff    <= '0;
         ms_start_ff   <= '0;
         ms_done_ff    <= MS_SAT;
         last_mm_ff    <= '0;
         last_valid_ff <= 1'b0;
      end else if (req_acc) begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         prev_echo_ff  <= echo_level;
         rise_seen_ff  <= rise_seen_in;
         us_pre_ff     <= us_pre_in;
         ms_pre_ff     <= ms_pre_in;
         echo_us_ff    <= echo_us_in;
         ms_start_ff   <= ms_start_in;
         ms_done_ff    <= ms_done_in;
         last_mm_ff    <= last_mm_in;
         last_valid_ff <= last_valid_in;
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_pop) begin
         out_valid_ff  <= req_acc | skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end else if (req_acc) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_pop) begin
         out_ff <= skid_valid_ff ? skid_ff : rsp_new;
      end else if (req_acc) begin
         skid_ff <= rsp_new;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.range_mm, out_ff.start_accepted,
                        out_ff.status, out_ff.trig};
   assign rsp_tuser  = out_ff.distance_valid;

   `UER_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid entry held while output register empty")
   `UER_ASSERT_NEXT(a_start_enters_busy, clock, reset, req_acc && start_ok,
      mode_ff == MODE_BUSY, "accepted start did not enter busy")
   `UER_ASSERT_IMPLIES(a_trig_only_busy, clock, reset, out_valid_ff && out_ff.trig,
      out_ff.status == STATUS_BUSY, "trigger driven outside a busy result")
   `UER_ASSERT_IMPLIES(a_done_is_valid, clock, reset,
      out_valid_ff && (out_ff.status == STATUS_DONE), out_ff.distance_valid,
      "done result without valid distance")
   `UER_ASSERT_IMPLIES(a_idle_no_rise, clock, reset, mode_ff == MODE_IDLE, !rise_seen_ff,
      "echo rise flag left set while idle")
   `UER_ASSERT_HOLDS(a_prescale_range, clock, reset, {1'b0, us_pre_ff} < US_WRAP,
      "microsecond prescaler out of range")

endmodule

// ===== sim/tb_ultrasonic_echo_ranging_top.sv =====
// testbench for ultrasonic_echo_ranging_top: streams start requests and echo pin samples,
// predicts the result of every transaction and compares it with the result stream
// depends on uer_pkg and the rtl of the ranging block
module tb_ultrasonic_echo_ranging_top;
   timeunit 1ns;
   timeprecision 1ps;

   import uer_pkg::*;

   localparam int SCALE_NUM   = 10;
   localparam int SCALE_DEN   = 58;
   localparam int DRAIN_LIMIT = 10000;

   typedef struct packed {
      logic       reconfigure;
      logic [7:0] timeout;
      logic [7:0] gap;
      logic       start;
      logic       echo;
      logic       pinned;
      status_type status;
      logic       accepted;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // start_req, echo_level, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // trig, status, start_accepted, range_mm, zero pad
   logic        rsp_tuser;   // distance_valid
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // typed expectation travelling with a transaction
   logic        pin_en;
   status_type  pin_status;
   logic        pin_accept;

   logic tx_idle_on;
   logic rx_idle_on;
   int   rx_hold_len;

   int mismatch_count;
   int readings_taken;
   int starts_taken;
   int ranges_measured;
   int timeouts_seen;

   rsp_type expected_q [$];

   // predictor state and register copies
   logic [7:0]  cfg_timeout    = TIMEOUT_RESET;
   logic [7:0]  cfg_gap        = GAP_RESET;
   logic [15:0] cfg_max_mm     = MAX_MM_RESET;
   logic        rng_busy       = 1'b0;
   logic [3:0]  rng_trig_us    = '0;
   logic        rng_prev_echo  = 1'b0;
   logic        rng_rise_seen  = 1'b0;
   int unsigned rng_us_pre     = 0;
   int unsigned rng_ms_pre     = 0;
   logic [17:0] rng_echo_us    = '0;
   logic [7:0]  rng_ms_start   = '0;
   logic [7:0]  rng_ms_done    = MS_SAT;
   logic [15:0] rng_last_mm    = '0;
   logic        rng_last_valid = 1'b0;

   row_type script [0:18] = '{
      '{1'b1, 8'd30,  8'd255, 1'b0, 1'b1, 1'b1, STATUS_IDLE,    1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b1, 1'b1, 1'b1, STATUS_BUSY,    1'b1},
      '{1'b0, 8'd0,   8'd0,   1'b1, 1'b1, 1'b1, STATUS_BUSY,    1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b1, STATUS_BUSY,    1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b1, 1'b1, STATUS_BUSY,    1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b1, STATUS_TIMEOUT, 1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b1, 1'b0, 1'b1, STATUS_IDLE,    1'b0},
      '{1'b1, 8'd0,   8'd0,   1'b1, 1'b0, 1'b1, STATUS_BUSY,    1'b1},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b1, STATUS_TIMEOUT, 1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b1, 1'b1, 1'b1, STATUS_BUSY,    1'b1},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b1, STATUS_TIMEOUT, 1'b0},
      '{1'b1, 8'd255, 8'd0,   1'b1, 1'b0, 1'b1, STATUS_BUSY,    1'b1},
      '{1'b0, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0, STATUS_IDLE,    1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0, STATUS_IDLE,    1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b1, 1'b0, STATUS_IDLE,    1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b1, 1'b1, 1'b0, STATUS_IDLE,    1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b1, STATUS_TIMEOUT, 1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b1, 1'b1, STATUS_IDLE,    1'b0},
      '{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b1, STATUS_IDLE,    1'b0}
   };

   ultrasonic_echo_ranging_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(80_000_000);
      $display("%0t ns: run did not complete in time", $time);
      $display("TB_ERROR");
      $finish;
   end

   function automatic void advance_time(output logic us_tick, output logic ms_tick);
      us_tick = 1'b0;
      ms_tick = 1'b0;
      rng_us_pre++;
      if (rng_us_pre >= CYCLES_PER_US) begin
         rng_us_pre = 0;
         us_tick    = 1'b1;
         rng_ms_pre++;
         if (rng_ms_pre >= US_PER_MS) begin
            rng_ms_pre = 0;
            ms_tick    = 1'b1;
         end
      end
   endfunction

   function automatic void close_measurement();
      rng_busy      = 1'b0;
      rng_rise_seen = 1'b0;
      rng_ms_done   = '0;
      rng_us_pre    = 0;
      rng_ms_pre    = 0;
   endfunction

   function automatic rsp_type step_ranger(input logic start, input logic echo);
      rsp_type     r;
      logic        rising;
      logic        falling;
      logic        us_tick;
      logic        ms_tick;
      int unsigned mm;
      rising        = echo && !rng_prev_echo;
      falling       = !echo && rng_prev_echo;
      rng_prev_echo = echo;
      r             = '0;
      r.status      = STATUS_IDLE;
      if (!rng_busy) begin
         if (start && rng_ms_done >= cfg_gap) begin
            rng_busy         = 1'b1;
            rng_trig_us      = '0;
            rng_rise_seen    = 1'b0;
            rng_echo_us      = '0;
            rng_ms_start     = '0;
            rng_us_pre       = 0;
            rng_ms_pre       = 0;
            r.start_accepted = 1'b1;
            r.status         = STATUS_BUSY;
         end else begin
            advance_time(us_tick, ms_tick);
            if (ms_tick && rng_ms_done != MS_SAT)
               rng_ms_done++;
         end
      end else begin
         advance_time(us_tick, ms_tick);
         if (us_tick) begin
            if (rng_trig_us < TRIG_END_US)
               rng_trig_us++;
            if (rng_rise_seen && rng_echo_us != ECHO_US_MAX)
               rng_echo_us++;
         end
         if (ms_tick && rng_ms_start != MS_SAT)
            rng_ms_start++;
         r.status = STATUS_BUSY;
         if (rising) begin
            rng_rise_seen = 1'b1;
            rng_echo_us   = '0;
         end else if (falling && rng_rise_seen) begin
            mm = (32'(rng_echo_us) * SCALE_NUM) / SCALE_DEN;
            if (mm == 0 || mm > cfg_max_mm) begin
               rng_last_valid = 1'b0;
               r.status       = STATUS_TIMEOUT;
            end else begin
               rng_last_mm    = mm[15:0];
               rng_last_valid = 1'b1;
               r.status       = STATUS_DONE;
            end
            close_measurement();
         end
         if (r.status == STATUS_BUSY && rng_ms_start >= cfg_timeout) begin
            rng_last_valid = 1'b0;
            r.status       = STATUS_TIMEOUT;
            close_measurement();
         end
         if (r.status == STATUS_BUSY && rng_trig_us >= TRIG_LOW_US && rng_trig_us < TRIG_END_US)
            r.trig = 1'b1;
      end
      r.range_mm       = rng_last_mm;
      r.distance_valid = rng_last_valid;
      return r;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned seen);
      if (want != seen) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type oldest;
      rsp_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted = step_ranger(req_tdata[0], req_tdata[1]);
            if (pin_en) begin
               predicted.status         = pin_status;
               predicted.start_accepted = pin_accept;
            end
            expected_q.push_back(predicted);
            readings_taken++;
            if (predicted.start_accepted)
               starts_taken++;
            if (predicted.status == STATUS_DONE)
               ranges_measured++;
            if (predicted.status == STATUS_TIMEOUT)
               timeouts_seen++;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_type'({rsp_tuser, rsp_tdata[19:0]});
            if (expected_q.size() == 0) begin
               $display("%0t ns: result transaction with none expected, actual %h", $time,
                        {rsp_tuser, rsp_tdata});
               mismatch_count++;
            end else begin
               oldest = expected_q.pop_front();
               compare_field("trig", oldest.trig, seen.trig);
               compare_field("status", oldest.status, seen.status);
               compare_field("start_accepted", oldest.start_accepted, seen.start_accepted);
               compare_field("range_mm", oldest.range_mm, seen.range_mm);
               compare_field("distance_valid", oldest.distance_valid, seen.distance_valid);
               compare_field("tdata padding", 0, rsp_tdata[23:20]);
            end
         end
      end
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rx_hold_len > 0) begin
            stall_left  = rx_hold_len - 1;
            rx_hold_len = 0;
            rsp_tready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_reading(input logic start, input logic echo, input logic pinned,
                               input status_type want_status, input logic want_accept);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, echo, start};
      pin_en     <= pinned;
      pin_status <= want_status;
      pin_accept <= want_accept;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic offer(input logic start, input logic echo);
      send_reading(start, echo, 1'b0, STATUS_IDLE, 1'b0);
   endtask

   // stop offering and let every outstanding result come back
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         $display("%0t ns: register %0d read back mismatch, expected %0d, actual %0d",
                  $time, idx, value, csr_prdata);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_TIMEOUT: cfg_timeout = value[7:0];
         CSR_GAP:     cfg_gap     = value[7:0];
         CSR_MAX_MM:  cfg_max_mm  = value[15:0];
         default:     ;
      endcase
   endtask

   task automatic configure(input logic [7:0] timeout, input logic [7:0] gap,
                            input logic [15:0] max_mm);
      settle_block();
      csr_write(CSR_TIMEOUT, {24'b0, timeout});
      csr_write(CSR_GAP, {24'b0, gap});
      csr_write(CSR_MAX_MM, {16'b0, max_mm});
   endtask

   // start, optional early echo, rise, echo pulse, fall, with noise in between
   task automatic run_measurements(input int count, input int span_lo, input int span_hi);
      int   span;
      logic pin_high;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6))
               offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         pin_high = ($urandom_range(0, 7) == 0);
         offer(1'b1, pin_high);
         repeat ($urandom_range(0, 8)) offer(1'($urandom_range(0, 1)), pin_high);
         if (pin_high)
            offer(1'($urandom_range(0, 1)), 1'b0);
         span = $urandom_range(span_hi, span_lo);
         offer(1'b0, 1'b1);
         repeat (span) offer(1'($urandom_range(0, 1)), 1'b1);
         offer(1'($urandom_range(0, 1)), 1'b0);
         repeat ($urandom_range(0, 3)) offer(1'b0, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      pin_en         = 1'b0;
      pin_status     = STATUS_IDLE;
      pin_accept     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      tx_idle_on     = 1'b1;
      rx_idle_on     = 1'b1;
      rx_hold_len    = 0;
      mismatch_count = 0;
      readings_taken = 0;
      starts_taken   = 0;
      ranges_measured = 0;
      timeouts_seen  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].reconfigure)
            configure(script[i].timeout, script[i].gap, MAX_MM_RESET);
         send_reading(script[i].start, script[i].echo, script[i].pinned, script[i].status,
                      script[i].accepted);
      end

      // echo long enough for a one millimetre reading
      configure(8'd30, 8'd0, 16'd1);
      run_measurements(1, 600, 620);

      configure(8'd255, 8'd0, 16'd5);
      rx_hold_len = 300;
      run_measurements(4, 0, 30);
      settle_block();
      run_measurements(2, 0, 30);

      configure(8'd100, 8'd254, 16'd3);
      run_measurements(2, 0, 30);

      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      configure(8'd200, 8'd0, 16'd65535);
      run_measurements(4, 0, 30);

      req_tvalid <= 1'b0;
      for (int w = 0; w < DRAIN_LIMIT && expected_q.size() != 0; w++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (expected_q.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived, actual none", $time,
                  expected_q.size());
         mismatch_count++;
      end
      $display("run covered %0d transactions with %0d accepted starts,", readings_taken,
               starts_taken);
      $display("%0d valid ranges and %0d timeouts over the table and four register settings",
               ranges_measured, timeouts_seen);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
